@@ design/fhp_pkg.sv @@
// Shared types and constants of the FLAC frame header probe.
package fhp_pkg;

	localparam int CountBits = 16;
	localparam int CmpBits = (CountBits > 16) ? CountBits : 16;
	localparam int QDepth = 2;
	localparam int QPtrBits = $clog2(QDepth);
	localparam int QCntBits = $clog2(QDepth + 1);

	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_NO_SYNC = 2'd1;
	localparam logic [1:0] ST_ENDED = 2'd2;

	localparam logic [1:0] CFG_SEARCH_LIMIT = 2'd0;
	localparam logic [1:0] CFG_DEFAULT_RATE = 2'd1;
	localparam logic [1:0] CFG_DEFAULT_BITS = 2'd2;

	localparam logic [15:0] ResetSearchLimit = 16'd4096;
	localparam logic [19:0] FallbackRate = 20'd44100;
	localparam logic [5:0] FallbackBits = 6'd16;
	localparam logic [15:0] ReservedBlock = 16'd4096;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_start;
		logic       stream_end;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] sync_offset;
		logic [19:0] sample_rate_hz;
		logic [3:0]  channel_count;
		logic [5:0]  sample_bits;
		logic [15:0] block_samples;
		logic [63:0] streaminfo_word;
	} out_item_t;

	typedef struct packed {
		logic [15:0] search_limit;
		logic [19:0] default_sample_rate;
		logic [5:0]  default_bits;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] sync_pos;
		logic [7:0]  hb0;
		logic [7:0]  hb1;
		logic [7:0]  hb2;
		logic [7:0]  hb3;
		logic [15:0] ext;
	} evt_t;

endpackage

@@ design/fhp_front.sv @@
// Byte parser: sync search, header byte capture and event generation.
module fhp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  fhp_pkg::in_item_t item,
	input  fhp_pkg::cfg_t    cfg,
	output logic             evt_push,
	output fhp_pkg::evt_t    evt
);
	import fhp_pkg::*;

	typedef enum logic [8:0] {
		PH_SEARCH    = 9'b000000001,
		PH_B2        = 9'b000000010,
		PH_B3        = 9'b000000100,
		PH_UTF8_LEAD = 9'b000001000,
		PH_UTF8_CONT = 9'b000010000,
		PH_BS_HI     = 9'b000100000,
		PH_BS_LO     = 9'b001000000,
		PH_SR_HI     = 9'b010000000,
		PH_SR_LO     = 9'b100000000
	} phase_t;

	function automatic logic [2:0] utf8_extra(input logic [7:0] b);
		logic [2:0] n;
		if (b[7] == 1'b0) n = 3'd0;
		else if (b[7:5] == 3'b110) n = 3'd1;
		else if (b[7:4] == 4'b1110) n = 3'd2;
		else if (b[7:3] == 5'b11110) n = 3'd3;
		else if (b[7:2] == 6'b111110) n = 3'd4;
		else if (b[7:1] == 7'b1111110) n = 3'd5;
		else if (b == 8'hFE) n = 3'd6;
		else n = 3'd0;
		return n;
	endfunction

	phase_t phase_q, phase_n, e_phase;
	logic [CountBits-1:0] cnt_q, cnt_n, e_cnt;
	logic [2:0] left_q, left_n, e_left;
	logic [15:0] ext_q, ext_n, e_ext;
	logic [15:0] sync_q, sync_n, e_sync;
	logic prev_ff_q, prev_ff_n, e_prev_ff;
	logic fin_q, fin_n, e_fin;
	logic [7:0] hb0_q, hb1_q, hb2_q, hb3_q;
	logic [7:0] hb0_n, hb1_n, hb2_n, hb3_n;
	logic [CmpBits-1:0] idx_w;
	logic utf_done, blk_done, done, fail_limit;

	always_comb begin
		e_phase   = item.stream_start ? PH_SEARCH : phase_q;
		e_cnt     = item.stream_start ? '0 : cnt_q;
		e_left    = item.stream_start ? 3'd0 : left_q;
		e_ext     = item.stream_start ? 16'd0 : ext_q;
		e_sync    = item.stream_start ? 16'd0 : sync_q;
		e_prev_ff = item.stream_start ? 1'b0 : prev_ff_q;
		e_fin     = item.stream_start ? 1'b0 : fin_q;

		phase_n = e_phase;
		cnt_n = e_cnt;
		left_n = e_left;
		ext_n = e_ext;
		sync_n = e_sync;
		prev_ff_n = e_prev_ff;
		fin_n = e_fin;
		hb0_n = hb0_q;
		hb1_n = hb1_q;
		hb2_n = hb2_q;
		hb3_n = hb3_q;
		utf_done = 1'b0;
		blk_done = 1'b0;
		done = 1'b0;
		fail_limit = 1'b0;
		idx_w = CmpBits'(e_cnt);

		if (!e_fin) begin
			unique case (e_phase)
				PH_SEARCH: begin
					if (e_cnt != {CountBits{1'b1}}) cnt_n = e_cnt + 1'b1;
					if (e_prev_ff && item.in_byte[7:3] == 5'h1F) begin
						sync_n = idx_w[15:0] - 16'd1;
						phase_n = PH_B2;
					end else begin
						prev_ff_n = (item.in_byte == 8'hFF);
						if (CmpBits'(cnt_n) >= CmpBits'(cfg.search_limit)) fail_limit = 1'b1;
					end
				end
				PH_B2: begin
					hb0_n = item.in_byte;
					phase_n = PH_B3;
				end
				PH_B3: begin
					hb1_n = item.in_byte;
					phase_n = PH_UTF8_LEAD;
				end
				PH_UTF8_LEAD: begin
					left_n = utf8_extra(item.in_byte);
					if (left_n == 3'd0) utf_done = 1'b1;
					else phase_n = PH_UTF8_CONT;
				end
				PH_UTF8_CONT: begin
					if (e_left != 3'd0) left_n = e_left - 3'd1;
					if (left_n == 3'd0) utf_done = 1'b1;
				end
				PH_BS_HI: begin
					hb2_n = item.in_byte;
					phase_n = PH_BS_LO;
				end
				PH_BS_LO: begin
					hb3_n = item.in_byte;
					blk_done = 1'b1;
				end
				PH_SR_HI: begin
					ext_n = {item.in_byte, 8'd0};
					phase_n = PH_SR_LO;
				end
				PH_SR_LO: begin
					ext_n = e_ext | {8'd0, item.in_byte};
					done = 1'b1;
				end
				default: phase_n = PH_SEARCH;
			endcase

			if (utf_done) begin
				hb2_n = 8'd0;
				hb3_n = 8'd0;
				if (hb0_q[7:4] == 4'd6) phase_n = PH_BS_LO;
				else if (hb0_q[7:4] == 4'd7) phase_n = PH_BS_HI;
				else blk_done = 1'b1;
			end
			if (blk_done) begin
				ext_n = 16'd0;
				if (hb0_q[3:0] == 4'd12) phase_n = PH_SR_LO;
				else if (hb0_q[3:0] == 4'd13 || hb0_q[3:0] == 4'd14) phase_n = PH_SR_HI;
				else done = 1'b1;
			end
			if (done) phase_n = PH_SEARCH;
		end

		evt.sync_pos = sync_n;
		evt.hb0 = hb0_n;
		evt.hb1 = hb1_n;
		evt.hb2 = hb2_n;
		evt.hb3 = hb3_n;
		evt.ext = ext_n;
		evt.status = ST_FOUND;
		evt_push = 1'b0;
		if (!e_fin) begin
			if (done) begin
				evt_push = accept;
				fin_n = 1'b1;
			end else if (fail_limit) begin
				evt_push = accept;
				evt.status = ST_NO_SYNC;
				fin_n = 1'b1;
			end else if (item.stream_end) begin
				evt_push = accept;
				evt.status = ST_ENDED;
				fin_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			cnt_q <= '0;
			left_q <= 3'd0;
			ext_q <= 16'd0;
			sync_q <= 16'd0;
			prev_ff_q <= 1'b0;
			fin_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			cnt_q <= cnt_n;
			left_q <= left_n;
			ext_q <= ext_n;
			sync_q <= sync_n;
			prev_ff_q <= prev_ff_n;
			fin_q <= fin_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hb0_q <= hb0_n;
			hb1_q <= hb1_n;
			hb2_q <= hb2_n;
			hb3_q <= hb3_n;
		end
	end

endmodule

@@ design/fhp_evt_queue.sv @@
// Short event queue between the byte parser and the decoder.
module fhp_evt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fhp_pkg::evt_t evt_in,
	input  logic          pop,
	output logic          empty,
	output logic          full,
	output fhp_pkg::evt_t evt_out
);
	import fhp_pkg::*;

	evt_t mem_q [QDepth];
	logic [QPtrBits-1:0] wr_q, rd_q;
	logic [QCntBits-1:0] cnt_q;
	logic do_push, do_pop;

	assign empty = (cnt_q == QCntBits'(0));
	assign full = (cnt_q == QCntBits'(QDepth));
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign evt_out = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= evt_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == QPtrBits'(QDepth - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == QPtrBits'(QDepth - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ design/fhp_back.sv @@
// Header decoder and result buffer.
module fhp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  fhp_pkg::cfg_t     cfg,
	input  logic              evt_valid,
	input  fhp_pkg::evt_t     evt,
	output logic              evt_pop,
	input  logic              pop,
	output logic              empty,
	output fhp_pkg::out_item_t result
);
	import fhp_pkg::*;

	function automatic logic [19:0] rate_table(input logic [3:0] code);
		logic [19:0] r;
		unique case (code)
			4'd1: r = 20'd88200;
			4'd2: r = 20'd176400;
			4'd3: r = 20'd192000;
			4'd4: r = 20'd8000;
			4'd5: r = 20'd16000;
			4'd6: r = 20'd22050;
			4'd7: r = 20'd24000;
			4'd8: r = 20'd32000;
			4'd9: r = 20'd44100;
			4'd10: r = 20'd48000;
			4'd11: r = 20'd96000;
			default: r = 20'd0;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] block_table(input logic [2:0] code);
		logic [15:0] b;
		unique case (code)
			3'd0: b = ReservedBlock;
			3'd1: b = 16'd192;
			3'd2: b = 16'd576;
			3'd3: b = 16'd1152;
			3'd4: b = 16'd2304;
			3'd5: b = 16'd4608;
			default: b = 16'd0;
		endcase
		return b;
	endfunction

	function automatic logic [5:0] size_table(input logic [2:0] code);
		logic [5:0] s;
		unique case (code)
			3'd1: s = 6'd8;
			3'd2: s = 6'd12;
			3'd4: s = 6'd16;
			3'd5: s = 6'd20;
			3'd6: s = 6'd24;
			default: s = 6'd0;
		endcase
		return s;
	endfunction

	out_item_t buf_q [QDepth];
	logic [QPtrBits-1:0] wr_q, rd_q;
	logic [QCntBits-1:0] cnt_q;
	logic do_pop, take;
	out_item_t dec;
	logic [3:0] rcode, bcode, ccode;
	logic [2:0] scode;
	logic [19:0] rate_raw, rate;
	logic [3:0] ch, ch_m1;
	logic [5:0] bits, bits_fb, bits_m1;
	logic [16:0] ext_blk;
	logic [15:0] block;

	always_comb begin
		rcode = evt.hb0[3:0];
		bcode = evt.hb0[7:4];
		ccode = evt.hb1[7:4];
		scode = evt.hb1[3:1];

		unique case (rcode)
			4'd12: rate_raw = 20'(evt.ext[7:0]) * 20'd1000;
			4'd13: rate_raw = 20'(evt.ext);
			4'd14: rate_raw = 20'(evt.ext) * 20'd10;
			default: rate_raw = rate_table(rcode);
		endcase
		if (rate_raw != 20'd0) rate = rate_raw;
		else if (cfg.default_sample_rate != 20'd0) rate = cfg.default_sample_rate;
		else rate = FallbackRate;

		ch = (ccode <= 4'd7) ? ccode + 4'd1 : 4'd2;
		ch_m1 = ch - 4'd1;

		bits_fb = (cfg.default_bits != 6'd0) ? cfg.default_bits : FallbackBits;
		if (bits_fb < 6'd4) bits_fb = 6'd4;
		if (bits_fb > 6'd32) bits_fb = 6'd32;
		bits = size_table(scode);
		if (bits == 6'd0) bits = bits_fb;
		bits_m1 = bits - 6'd1;

		ext_blk = {1'b0, evt.hb2, evt.hb3} + 17'd1;
		if (bcode[3]) block = 16'd256 << bcode[2:0];
		else if (bcode == 4'd6 || bcode == 4'd7) block = ext_blk[16] ? 16'hFFFF : ext_blk[15:0];
		else block = block_table(bcode[2:0]);

		dec = '0;
		dec.status = evt.status;
		if (evt.status == ST_FOUND) begin
			dec.sync_offset = evt.sync_pos;
			dec.sample_rate_hz = rate;
			dec.channel_count = ch;
			dec.sample_bits = bits;
			dec.block_samples = block;
			dec.streaminfo_word = {rate, ch_m1[2:0], bits_m1[4:0], 36'd0};
		end
	end

	assign empty = (cnt_q == QCntBits'(0));
	assign do_pop = pop && !empty;
	assign take = evt_valid && ((cnt_q != QCntBits'(QDepth)) || do_pop);
	assign evt_pop = take;
	assign result = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (take) buf_q[wr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (take) wr_q <= (wr_q == QPtrBits'(QDepth - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == QPtrBits'(QDepth - 1)) ? '0 : rd_q + 1'b1;
			if (take && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !take) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ design/flac_frame_header_probe_unit.sv @@
// Top level of the FLAC frame header probe.
// Feed stream bytes through push/full; one byte is taken per clock while full is low. The
// parser scans for a frame sync, captures the code and extension bytes, skips the UTF-8
// frame number, then posts one result per stream (header found, no sync within search_limit
// bytes, or stream ended) until the next byte marked stream_start. A result is written into
// the parser-to-decoder event queue when the byte that completes it is taken; the decoder
// decodes it and writes it into the two-entry result queue once that queue has room.
// The sustained rate is one byte per cycle, limited by the single-byte parser state machine;
// input stalls only when both queues back up behind an unread result.
module flac_frame_header_probe_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  fhp_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output fhp_pkg::out_item_t result,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [19:0]        wr_data
);
	import fhp_pkg::*;

	cfg_t cfg_q;
	logic accept, evt_push, q_empty, q_full, q_pop;
	evt_t evt_in, evt_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.search_limit <= ResetSearchLimit;
			cfg_q.default_sample_rate <= FallbackRate;
			cfg_q.default_bits <= FallbackBits;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_SEARCH_LIMIT: cfg_q.search_limit <= wr_data[15:0];
				CFG_DEFAULT_RATE: cfg_q.default_sample_rate <= wr_data;
				CFG_DEFAULT_BITS: cfg_q.default_bits <= wr_data[5:0];
				default: ;
			endcase
		end
	end

	assign full = q_full;
	assign accept = push && !q_full;

	fhp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.item(item),
		.cfg(cfg_q),
		.evt_push(evt_push),
		.evt(evt_in)
	);

	fhp_evt_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(evt_push),
		.evt_in(evt_in),
		.pop(q_pop),
		.empty(q_empty),
		.full(q_full),
		.evt_out(evt_out)
	);

	fhp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.evt_valid(!q_empty),
		.evt(evt_out),
		.evt_pop(q_pop),
		.pop(pop),
		.empty(empty),
		.result(result)
	);

endmodule

@@ design/fhp_checker.sv @@
// Port-level checks of the FLAC frame header probe and their binding.
module fhp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input fhp_pkg::out_item_t result
);
	import fhp_pkg::*;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.status == ST_FOUND || result.status == ST_NO_SYNC ||
			result.status == ST_ENDED))
		else $error("result status outside defined codes");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status != ST_FOUND) |-> (result.sync_offset == 16'd0 &&
			result.sample_rate_hz == 20'd0 && result.block_samples == 16'd0 &&
			result.streaminfo_word == 64'd0))
		else $error("failed result carries nonzero fields");

	a_found_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status == ST_FOUND) |-> (result.sample_bits >= 6'd4 &&
			result.sample_bits <= 6'd32 && result.channel_count >= 4'd1 &&
			result.channel_count <= 4'd8 && result.block_samples != 16'd0 &&
			result.sample_rate_hz != 20'd0))
		else $error("decoded header field out of range");

	a_word_packing: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status == ST_FOUND) |-> (result.streaminfo_word[63:44] ==
			result.sample_rate_hz && result.streaminfo_word[35:0] == 36'd0))
		else $error("streaminfo word does not match decoded rate");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed before transfer");

endmodule

bind flac_frame_header_probe_unit fhp_checker u_fhp_checker (.*);

@@ sim/testbench.sv @@
// Testbench of the FLAC frame header probe: directed and random streams against a predictor.
module testbench;
	import fhp_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 400;

	typedef enum logic [3:0] {
		PS_SEARCH, PS_CODE, PS_CHAN, PS_NUM_LEAD, PS_NUM_CONT,
		PS_BLK_HI, PS_BLK_LO, PS_RATE_HI, PS_RATE_LO
	} hdr_phase_e;

	typedef struct {
		in_item_t  it;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	localparam out_item_t NO_RESULT = '0;
	localparam out_item_t EXP_ENDED = '{ST_ENDED, 16'd0, 20'd0, 4'd0, 6'd0, 16'd0, 64'd0};
	localparam out_item_t EXP_PLAIN = '{ST_FOUND, 16'd0, 20'd44100, 4'd2, 6'd16, 16'd4096,
		{20'd44100, 3'd1, 5'd15, 36'd0}};
	localparam out_item_t EXP_WIDE = '{ST_FOUND, 16'd1, 20'd655350, 4'd2, 6'd16, 16'd65535,
		{20'd655350, 3'd1, 5'd15, 36'd0}};
	localparam out_item_t EXP_ZERO_EXT = '{ST_FOUND, 16'd0, 20'd44100, 4'd8, 6'd16, 16'd1,
		{20'd44100, 3'd7, 5'd15, 36'd0}};

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  item;
	logic      empty;
	logic      pop;
	out_item_t result;
	logic      wr_en;
	logic [1:0]  wr_index;
	logic [19:0] wr_data;

	flac_frame_header_probe_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// header parser copy
	hdr_phase_e  hp_phase;
	logic [15:0] hp_count;
	logic [7:0]  hp_hdr [4];
	logic [2:0]  hp_num_left;
	logic [15:0] hp_ext;
	logic [15:0] hp_sync;
	bit          hp_prev_ff;
	bit          hp_done;
	logic [15:0] lim_reg;
	logic [19:0] rate_reg;
	logic [5:0]  bits_reg;

	out_item_t   pending_results [$];
	out_item_t   want_now;
	dir_row_t    dir_rows [$];
	int          errors;
	int          taken;
	int          burst_left;
	int unsigned cycle_count;
	int          hold_seq;
	int          hold_seen;
	int          hold_left;
	int          pop_mode;
	int          mode_left;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function void restart_stream();
		hp_phase = PS_SEARCH;
		hp_count = '0;
		hp_hdr = '{default: 8'h00};
		hp_num_left = '0;
		hp_ext = '0;
		hp_sync = '0;
		hp_prev_ff = 1'b0;
		hp_done = 1'b0;
	endfunction

	function bit close_block();
		hp_ext = '0;
		if (hp_hdr[0][3:0] == 4'd12) begin
			hp_phase = PS_RATE_LO;
			return 1'b0;
		end
		if (hp_hdr[0][3:0] == 4'd13 || hp_hdr[0][3:0] == 4'd14) begin
			hp_phase = PS_RATE_HI;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function bit close_number();
		hp_hdr[2] = 8'h00;
		hp_hdr[3] = 8'h00;
		if (hp_hdr[0][7:4] == 4'd6) begin
			hp_phase = PS_BLK_LO;
			return 1'b0;
		end
		if (hp_hdr[0][7:4] == 4'd7) begin
			hp_phase = PS_BLK_HI;
			return 1'b0;
		end
		return close_block();
	endfunction

	function logic [2:0] utf8_tail(input logic [7:0] b);
		casez (b)
			8'b0???????: return 3'd0;
			8'b110?????: return 3'd1;
			8'b1110????: return 3'd2;
			8'b11110???: return 3'd3;
			8'b111110??: return 3'd4;
			8'b1111110?: return 3'd5;
			8'hFE:       return 3'd6;
			default:     return 3'd0;
		endcase
	endfunction

	function out_item_t decode_header();
		out_item_t r;
		logic [3:0] bcode, rcode, ccode;
		logic [2:0] scode;
		int unsigned rate, ch, bits, blk;
		bcode = hp_hdr[0][7:4];
		rcode = hp_hdr[0][3:0];
		ccode = hp_hdr[1][7:4];
		scode = hp_hdr[1][3:1];
		case (rcode)
			4'd1:  rate = 88200;
			4'd2:  rate = 176400;
			4'd3:  rate = 192000;
			4'd4:  rate = 8000;
			4'd5:  rate = 16000;
			4'd6:  rate = 22050;
			4'd7:  rate = 24000;
			4'd8:  rate = 32000;
			4'd9:  rate = 44100;
			4'd10: rate = 48000;
			4'd11: rate = 96000;
			4'd12: rate = hp_ext[7:0] * 1000;
			4'd13: rate = hp_ext;
			4'd14: rate = hp_ext * 10;
			default: rate = 0;
		endcase
		if (rate == 0)
			rate = (rate_reg != 0) ? rate_reg : FallbackRate;
		rate = rate & 32'hFFFFF;
		ch = (ccode <= 4'd7) ? ccode + 1 : 2;
		case (scode)
			3'd1: bits = 8;
			3'd2: bits = 12;
			3'd4: bits = 16;
			3'd5: bits = 20;
			3'd6: bits = 24;
			default: begin
				bits = (bits_reg != 0) ? bits_reg : FallbackBits;
				if (bits < 4)
					bits = 4;
				if (bits > 32)
					bits = 32;
			end
		endcase
		if (bcode >= 4'd8) begin
			blk = 256 << (bcode - 8);
		end else if (bcode == 4'd6 || bcode == 4'd7) begin
			blk = {hp_hdr[2], hp_hdr[3]} + 1;
			if (blk > 65535)
				blk = 65535;
		end else begin
			case (bcode)
				4'd0: blk = ReservedBlock;
				4'd1: blk = 192;
				4'd2: blk = 576;
				4'd3: blk = 1152;
				4'd4: blk = 2304;
				default: blk = 4608;
			endcase
		end
		r.status = ST_FOUND;
		r.sync_offset = hp_sync;
		r.sample_rate_hz = rate[19:0];
		r.channel_count = ch[3:0];
		r.sample_bits = bits[5:0];
		r.block_samples = blk[15:0];
		r.streaminfo_word = {rate[19:0], 3'(ch - 1), 5'(bits - 1), 36'd0};
		return r;
	endfunction

	function void parse_byte(input in_item_t it, output bit made, output out_item_t r,
			output bit ignored);
		logic [15:0] idx;
		logic [7:0] b;
		bit fin;
		b = it.in_byte;
		made = 1'b0;
		ignored = 1'b0;
		fin = 1'b0;
		r = '0;
		if (it.stream_start)
			restart_stream();
		if (hp_done) begin
			ignored = 1'b1;
			return;
		end
		case (hp_phase)
			PS_SEARCH: begin
				idx = hp_count;
				if (hp_count != 16'hFFFF)
					hp_count = hp_count + 1'b1;
				if (hp_prev_ff && b[7:3] == 5'h1F) begin
					hp_sync = idx - 1'b1;
					hp_phase = PS_CODE;
				end else begin
					hp_prev_ff = (b == 8'hFF);
					if (hp_count >= lim_reg) begin
						hp_done = 1'b1;
						made = 1'b1;
						r.status = ST_NO_SYNC;
						return;
					end
				end
			end
			PS_CODE: begin
				hp_hdr[0] = b;
				hp_phase = PS_CHAN;
			end
			PS_CHAN: begin
				hp_hdr[1] = b;
				hp_phase = PS_NUM_LEAD;
			end
			PS_NUM_LEAD: begin
				hp_num_left = utf8_tail(b);
				if (hp_num_left == 0)
					fin = close_number();
				else
					hp_phase = PS_NUM_CONT;
			end
			PS_NUM_CONT: begin
				if (hp_num_left > 0)
					hp_num_left = hp_num_left - 1'b1;
				if (hp_num_left == 0)
					fin = close_number();
			end
			PS_BLK_HI: begin
				hp_hdr[2] = b;
				hp_phase = PS_BLK_LO;
			end
			PS_BLK_LO: begin
				hp_hdr[3] = b;
				fin = close_block();
			end
			PS_RATE_HI: begin
				hp_ext = {b, 8'h00};
				hp_phase = PS_RATE_LO;
			end
			default: begin
				hp_ext = hp_ext | {8'h00, b};
				fin = 1'b1;
			end
		endcase
		if (fin) begin
			hp_done = 1'b1;
			hp_phase = PS_SEARCH;
			made = 1'b1;
			r = decode_header();
			return;
		end
		if (it.stream_end) begin
			hp_done = 1'b1;
			made = 1'b1;
			r.status = ST_ENDED;
		end
	endfunction

	task send(input in_item_t it, input bit typed, input out_item_t want);
		bit made, ignored;
		out_item_t r;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(100, 300);
			end else begin
				push <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end
		end
		burst_left--;
		item <= it;
		push <= 1'b1;
		do @(posedge clk); while (full);
		parse_byte(it, made, r, ignored);
		if (made)
			pending_results.push_back(typed ? want : r);
		if (!ignored)
			taken++;
	endtask

	task wait_idle();
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task cfg_put(input logic [1:0] idx, input logic [19:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		case (idx)
			CFG_SEARCH_LIMIT: lim_reg = data[15:0];
			CFG_DEFAULT_RATE: rate_reg = data;
			CFG_DEFAULT_BITS: bits_reg = data[5:0];
			default: ;
		endcase
	endtask

	task apply_config(input int limit, input int rate, input int bits);
		cfg_put(CFG_SEARCH_LIMIT, 20'(limit));
		cfg_put(CFG_DEFAULT_RATE, 20'(rate));
		cfg_put(CFG_DEFAULT_BITS, 20'(bits));
		wr_en <= 1'b0;
	endtask

	task row(input logic [7:0] b, input bit s, input bit e, input bit typed,
			input out_item_t want);
		dir_row_t d;
		d.it.in_byte = b;
		d.it.stream_start = s;
		d.it.stream_end = e;
		d.typed = typed;
		d.want = want;
		dir_rows.push_back(d);
	endtask

	// pre_len >= 0 forces a clean header after that many sync-free bytes
	task gen_stream(input int pre_len);
		logic [7:0] bytes [$];
		logic [7:0] cb, lead;
		int kind, n, i, cut, conts, nblk, nrate;
		bit forced;
		in_item_t it;
		forced = (pre_len >= 0);
		kind = forced ? 0 : $urandom_range(0, 99);
		cut = -1;
		if (kind < 70) begin
			if (!forced)
				pre_len = $urandom_range(0, 6);
			repeat (pre_len) bytes.push_back(8'($urandom_range(0, 254)));
			bytes.push_back(8'hFF);
			bytes.push_back({5'h1F, 3'($urandom_range(0, 7))});
			cb = 8'($urandom_range(0, 255));
			bytes.push_back(cb);
			bytes.push_back(8'($urandom_range(0, 255)));
			n = $urandom_range(0, 7);
			conts = (n < 7) ? n : 0;
			case (n)
				0: lead = {1'b0, 7'($urandom_range(0, 127))};
				1: lead = {3'b110, 5'($urandom_range(0, 31))};
				2: lead = {4'b1110, 4'($urandom_range(0, 15))};
				3: lead = {5'b11110, 3'($urandom_range(0, 7))};
				4: lead = {6'b111110, 2'($urandom_range(0, 3))};
				5: lead = {7'b1111110, 1'($urandom_range(0, 1))};
				6: lead = 8'hFE;
				default: lead = $urandom_range(0, 1) ? {2'b10, 6'($urandom_range(0, 63))} : 8'hFF;
			endcase
			bytes.push_back(lead);
			nblk = (cb[7:4] == 4'd6) ? 1 : (cb[7:4] == 4'd7) ? 2 : 0;
			nrate = (cb[3:0] == 4'd12) ? 1 : (cb[3:0] == 4'd13 || cb[3:0] == 4'd14) ? 2 : 0;
			repeat (conts + nblk + nrate + $urandom_range(0, 3))
				bytes.push_back(8'($urandom_range(0, 255)));
			if (!forced && $urandom_range(0, 6) == 0)
				cut = $urandom_range(0, bytes.size() - 1);
		end else begin
			n = $urandom_range(1, 40);
			repeat (n) begin
				if (kind < 85 || $urandom_range(0, 1) == 0)
					bytes.push_back(8'($urandom_range(0, 255)));
				else
					bytes.push_back($urandom_range(0, 1) ? 8'hFF : {5'h1F, 3'($urandom_range(0, 7))});
			end
			if ($urandom_range(0, 1))
				cut = bytes.size() - 1;
		end
		for (i = 0; i < bytes.size(); i++) begin
			it.in_byte = bytes[i];
			it.stream_start = (i == 0) || (!forced && $urandom_range(0, 63) == 0);
			it.stream_end = (i == cut) || (!forced && $urandom_range(0, 47) == 0);
			send(it, 1'b0, NO_RESULT);
		end
	endtask

	task run_random(input int count);
		int start;
		start = taken;
		while (taken - start < count) begin
			gen_stream(-1);
			if ($urandom_range(0, 39) == 0)
				wait_idle();
		end
		wait_idle();
	endtask

	task check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				$error("unexpected transfer: status %0d, sync_offset %0d",
					result.status, result.sync_offset);
				errors++;
			end else begin
				want_now = pending_results.pop_front();
				check_field("status", 64'(want_now.status), 64'(result.status));
				check_field("sync_offset", 64'(want_now.sync_offset), 64'(result.sync_offset));
				check_field("sample_rate_hz", 64'(want_now.sample_rate_hz),
					64'(result.sample_rate_hz));
				check_field("channel_count", 64'(want_now.channel_count),
					64'(result.channel_count));
				check_field("sample_bits", 64'(want_now.sample_bits), 64'(result.sample_bits));
				check_field("block_samples", 64'(want_now.block_samples),
					64'(result.block_samples));
				check_field("streaminfo_word", want_now.streaminfo_word, result.streaminfo_word);
			end
		end
	end

	always @(posedge clk) begin
		if (hold_seen != hold_seq) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (mode_left == 0) begin
			pop_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(32, 200);
		end else begin
			mode_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			case (pop_mode)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom_range(0, 1));
				2: pop <= ($urandom_range(0, 3) == 0);
				default: pop <= cycle_count[3];
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		item = '0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		errors = 0;
		taken = 0;
		burst_left = 0;
		cycle_count = 0;
		hold_seq = 0;
		hold_seen = 0;
		hold_left = 0;
		pop_mode = 0;
		mode_left = 0;
		lim_reg = ResetSearchLimit;
		rate_reg = FallbackRate;
		bits_reg = FallbackBits;
		restart_stream();

		// one-byte stream that ends at once
		row(8'h00, 1, 1, 1, EXP_ENDED);
		// common header, then a byte after the result that must be dropped
		row(8'hFF, 1, 0, 0, NO_RESULT);
		row(8'hF8, 0, 0, 0, NO_RESULT);
		row(8'hC9, 0, 0, 0, NO_RESULT);
		row(8'h18, 0, 0, 0, NO_RESULT);
		row(8'h00, 0, 0, 1, EXP_PLAIN);
		row(8'hAB, 0, 1, 0, NO_RESULT);
		// two-byte extensions, all-ones fields, saturated block size
		row(8'h12, 1, 0, 0, NO_RESULT);
		row(8'hFF, 0, 0, 0, NO_RESULT);
		row(8'hFF, 0, 0, 0, NO_RESULT);
		row(8'h7E, 0, 0, 0, NO_RESULT);
		row(8'hFF, 0, 0, 0, NO_RESULT);
		row(8'hE0, 0, 0, 0, NO_RESULT);
		row(8'h00, 0, 0, 0, NO_RESULT);
		row(8'h00, 0, 0, 0, NO_RESULT);
		row(8'hFF, 0, 0, 0, NO_RESULT);
		row(8'hFF, 0, 0, 0, NO_RESULT);
		row(8'hFF, 0, 0, 0, NO_RESULT);
		row(8'hFF, 0, 0, 1, EXP_WIDE);
		// bad number lead, one-byte extensions of zero, eight channels
		row(8'hFF, 1, 0, 0, NO_RESULT);
		row(8'hF9, 0, 0, 0, NO_RESULT);
		row(8'h6C, 0, 0, 0, NO_RESULT);
		row(8'h70, 0, 0, 0, NO_RESULT);
		row(8'h80, 0, 0, 0, NO_RESULT);
		row(8'h00, 0, 0, 0, NO_RESULT);
		row(8'h00, 0, 0, 1, EXP_ZERO_EXT);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
		wait_idle();

		// hold the output side and keep feeding one-byte streams until input stalls
		hold_seq++;
		repeat (16)
			send('{8'($urandom_range(0, 255)), 1'b1, 1'b1}, 1'b0, NO_RESULT);
		wait_idle();

		run_random(70);

		apply_config(16, 1, 4);
		run_random(80);

		apply_config(65535, 1048575, 32);
		gen_stream($urandom_range(20, 60));
		run_random(80);

		repeat (2) begin
			apply_config($urandom_range(0, 3) == 0 ? $urandom_range(16, 65535) :
				$urandom_range(16, 80), $urandom_range(1, 1048575), $urandom_range(4, 32));
			run_random(80);
		end

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ flac_frame_header_probe_unit.f @@
design/fhp_pkg.sv
design/fhp_front.sv
design/fhp_evt_queue.sv
design/fhp_back.sv
design/flac_frame_header_probe_unit.sv
design/fhp_checker.sv
sim/testbench.sv
